// ----- hdl/sor_pkg.sv -----
// package for the spiral order reader
// holds direction codes, request and register codes, and the control struct
// no dependencies
`default_nettype none

package sor_pkg;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } t_dir;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int  PADDR_W      = 3;
    localparam int  PDATA_W      = 32;
    localparam int  CFG_W        = 5;
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam int RST_NUM_ROWS = 4;
    localparam int RST_NUM_COLS = 6;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
    } t_addr_cmd;

endpackage

`default_nettype wire

// ----- hdl/sor_if.sv -----
// item channels of the spiral order reader
// depends on sor_pkg for field widths
`default_nettype none

interface sor_in_if;
    import sor_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [VALUE_W-1:0] load_value;

    modport source (output valid, output req_type, output load_value, input ready);
    modport sink (input valid, input req_type, input load_value, output ready);
endinterface

interface sor_out_if;
    import sor_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] elem_value;
    logic [POS_W-1:0]          elem_row;
    logic [POS_W-1:0]          elem_col;
    logic                      last;

    modport source (output valid, output elem_value, output elem_row, output elem_col,
                    output last, input ready);
    modport sink (input valid, input elem_value, input elem_row, input elem_col,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/spiral_order_reader_top.sv -----
// spiral order reader top: configuration registers, matrix store, address generator, read stage, output register
// depends on sor_pkg, sor_if, sor_cfg, sor_addr, sor_mem
//
//  channel  | dir | handshake              | payload
//  i_in     | in  | valid/ready            | req_type, load_value
//  o_out    | out | valid/ready            | elem_value, elem_row, elem_col, last
//  apb      | in  | psel/penable, pready=1 | paddr, pwdata, prdata
//
// a load is written in the cycle it is accepted and gives no item
// a read fetches the store into the read stage and moves to the output register once that is free
// one item per cycle sustained while the output is not stalled; the single memory read port sets this
// synchronous active-low reset clears control state; the store is not cleared
// a stalled output holds the read stage, which then holds i_in.ready low
`default_nettype none

module spiral_order_reader_top
    import sor_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    sor_in_if.sink                  i_in,
    sor_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [RW-1:0]             w_eff_rows;
    logic [CW-1:0]             w_eff_cols;
    logic                      w_clear;
    t_addr_cmd                 w_cmd;
    logic [AW-1:0]             w_waddr, w_raddr;
    logic [POS_W-1:0]          w_row, w_col;
    logic                      w_last;
    logic signed [VALUE_W-1:0] w_rdata;

    logic                      w_in_acc, w_is_read, w_rd_move;
    logic                      r_rd_valid, n_rd_valid;
    logic [POS_W-1:0]          r_rd_row, r_rd_col;
    logic                      r_rd_last;
    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [POS_W-1:0]          r_out_row, r_out_col;
    logic                      r_out_last;

    sor_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_eff_rows (w_eff_rows),
        .o_eff_cols (w_eff_cols),
        .o_clear    (w_clear)
    );

    sor_addr #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eff_rows (w_eff_rows),
        .i_eff_cols (w_eff_cols),
        .i_cmd      (w_cmd),
        .o_waddr    (w_waddr),
        .o_raddr    (w_raddr),
        .o_row      (w_row),
        .o_col      (w_col),
        .o_last     (w_last)
    );

    sor_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_cmd.load),
        .i_waddr (w_waddr),
        .i_wdata (i_in.load_value),
        .i_re    (w_cmd.step),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_is_read  = (i_in.req_type == REQ_READ);
    assign w_rd_move  = r_rd_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_rd_valid || w_rd_move;

    assign w_cmd.clear = w_clear;
    assign w_cmd.load  = w_in_acc && !w_is_read;
    assign w_cmd.step  = w_in_acc && w_is_read;

    always_comb begin
        n_rd_valid = r_rd_valid;
        if (w_cmd.step) begin
            n_rd_valid = 1'b1;
        end else if (w_rd_move) begin
            n_rd_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_rd_move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.step) begin
            r_rd_row  <= w_row;
            r_rd_col  <= w_col;
            r_rd_last <= w_last;
        end
        if (w_rd_move) begin
            r_out_value <= w_rdata;
            r_out_row   <= r_rd_row;
            r_out_col   <= r_rd_col;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.elem_value = r_out_value;
    assign o_out.elem_row   = r_out_row;
    assign o_out.elem_col   = r_out_col;
    assign o_out.last       = r_out_last;

`ifndef SYNTHESIS
    a_read_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |=> r_rd_valid)
        else $error("accepted read item did not enter the read stage");

    a_load_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !r_rd_valid)
        else $error("read stage busy after a load item");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |=> r_out_valid)
        else $error("read stage item not held in output register");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rd_valid))
        else $error("output item appeared without a read stage item");
`endif

endmodule

`default_nettype wire

// ----- hdl/sor_cfg.sv -----
// configuration registers of the spiral order reader, apb-style write and read
// clamps the matrix size to the store and maps a zero size to one; depends on sor_pkg
`default_nettype none

module sor_cfg
    import sor_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int RW = $clog2(MAX_ROWS + 1),
    localparam int CW = $clog2(MAX_COLS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [RW-1:0]      o_eff_rows,
    output logic      [CW-1:0]      o_eff_cols,
    output logic                    o_clear
);

    logic [CFG_W-1:0] r_num_rows, n_num_rows;
    logic [CFG_W-1:0] r_num_cols, n_num_cols;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_clear = w_wr;

    always_comb begin
        n_num_rows = r_num_rows;
        n_num_cols = r_num_cols;
        if (w_wr) begin
            case (paddr[2])
                REG_NUM_ROWS: n_num_rows = pwdata[CFG_W-1:0];
                REG_NUM_COLS: n_num_cols = pwdata[CFG_W-1:0];
                default:      n_num_cols = r_num_cols;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_W'(RST_NUM_ROWS);
            r_num_cols <= CFG_W'(RST_NUM_COLS);
        end else begin
            r_num_rows <= n_num_rows;
            r_num_cols <= n_num_cols;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NUM_ROWS: prdata = PDATA_W'(r_num_rows);
            REG_NUM_COLS: prdata = PDATA_W'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    // sizes follow a write in its own cycle so the walk restart sees them
    always_comb begin
        if (n_num_rows == '0) begin
            o_eff_rows = RW'(1);
        end else if (int'(n_num_rows) > MAX_ROWS) begin
            o_eff_rows = RW'(MAX_ROWS);
        end else begin
            o_eff_rows = RW'(n_num_rows);
        end
        if (n_num_cols == '0) begin
            o_eff_cols = CW'(1);
        end else if (int'(n_num_cols) > MAX_COLS) begin
            o_eff_cols = CW'(MAX_COLS);
        end else begin
            o_eff_cols = CW'(n_num_cols);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sor_mem.sv -----
// matrix store: one write port, one read port with registered read data
// depends on sor_pkg for the word width
`default_nettype none

module sor_mem
    import sor_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic signed [VALUE_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic signed      [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sor_addr.sv -----
// address generator: raster load index and clockwise spiral walk with bounds
// depends on sor_pkg for direction codes and the command struct
`default_nettype none

module sor_addr
    import sor_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int RW  = $clog2(MAX_ROWS + 1),
    localparam int CW  = $clog2(MAX_COLS + 1),
    localparam int DEPTH = MAX_ROWS * MAX_COLS,
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int PW0 = ((RW > CW) ? RW : CW) + 1,
    localparam int PW  = (PW0 < 5) ? 5 : PW0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [RW-1:0] i_eff_rows,
    input  wire logic [CW-1:0] i_eff_cols,
    input  wire t_addr_cmd     i_cmd,
    output logic      [AW-1:0] o_waddr,
    output logic      [AW-1:0] o_raddr,
    output logic [POS_W-1:0]   o_row,
    output logic [POS_W-1:0]   o_col,
    output logic               o_last
);

    localparam int LW = RW + CW;
    localparam int RST_ROWS = (RST_NUM_ROWS > MAX_ROWS) ? MAX_ROWS : RST_NUM_ROWS;
    localparam int RST_COLS = (RST_NUM_COLS > MAX_COLS) ? MAX_COLS : RST_NUM_COLS;
    localparam logic signed [PW-1:0] ONE = PW'(1);

    logic signed [PW-1:0] r_row, r_col, r_rb, r_bb, r_tb, r_lb;
    logic signed [PW-1:0] n_row, n_col, n_rb, n_bb, n_tb, n_lb;
    t_dir                 r_dir, n_dir;
    logic [LW-1:0]        r_lidx, n_lidx;
    logic                 w_done;
    logic signed [PW-1:0] w_rows_s, w_cols_s;
    logic [LW-1:0]        w_cells;
    logic [LW-1:0]        w_lidx_inc;
    logic [LW:0]          w_raddr;

    assign w_rows_s   = signed'(PW'(i_eff_rows));
    assign w_cols_s   = signed'(PW'(i_eff_cols));
    assign w_cells    = LW'(i_eff_rows) * LW'(i_eff_cols);
    assign w_lidx_inc = r_lidx + LW'(1);
    assign w_raddr    = (LW + 1)'(r_row[RW-1:0]) * (LW + 1)'(i_eff_cols)
                      + (LW + 1)'(r_col[CW-1:0]);

    assign o_raddr = w_raddr[AW-1:0];
    assign o_waddr = r_lidx[AW-1:0];
    assign o_row   = r_row[POS_W-1:0];
    assign o_col   = r_col[POS_W-1:0];
    assign o_last  = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_dir  <= DIR_RIGHT;
            r_rb   <= PW'(RST_COLS);
            r_bb   <= PW'(RST_ROWS);
            r_tb   <= '0;
            r_lb   <= -ONE;
            r_lidx <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_dir  <= n_dir;
            r_rb   <= n_rb;
            r_bb   <= n_bb;
            r_tb   <= n_tb;
            r_lb   <= n_lb;
            r_lidx <= n_lidx;
        end
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_dir  = r_dir;
        n_rb   = r_rb;
        n_bb   = r_bb;
        n_tb   = r_tb;
        n_lb   = r_lb;
        n_lidx = r_lidx;
        w_done = 1'b0;

        case (r_dir)
            DIR_RIGHT: begin
                if (r_col + ONE < r_rb) begin
                    n_col = r_col + ONE;
                end else begin
                    n_rb   = r_rb - ONE;
                    n_dir  = DIR_DOWN;
                    n_row  = r_row + ONE;
                    w_done = (r_row + ONE == r_bb);
                end
            end
            DIR_DOWN: begin
                if (r_row + ONE < r_bb) begin
                    n_row = r_row + ONE;
                end else begin
                    n_bb   = r_bb - ONE;
                    n_dir  = DIR_LEFT;
                    n_col  = r_col - ONE;
                    w_done = (r_col - ONE == r_lb);
                end
            end
            DIR_LEFT: begin
                if (r_col - ONE > r_lb) begin
                    n_col = r_col - ONE;
                end else begin
                    n_lb   = r_lb + ONE;
                    n_dir  = DIR_UP;
                    n_row  = r_row - ONE;
                    w_done = (r_row - ONE == r_tb);
                end
            end
            default: begin
                if (r_row - ONE > r_tb) begin
                    n_row = r_row - ONE;
                end else begin
                    n_tb   = r_tb + ONE;
                    n_dir  = DIR_RIGHT;
                    n_col  = r_col + ONE;
                    w_done = (r_col + ONE == r_rb);
                end
            end
        endcase

        if (!i_cmd.step) begin
            n_row = r_row;
            n_col = r_col;
            n_dir = r_dir;
            n_rb  = r_rb;
            n_bb  = r_bb;
            n_tb  = r_tb;
            n_lb  = r_lb;
        end

        // restart on a size write, on every load, and after the final element
        if (i_cmd.clear || i_cmd.load || (i_cmd.step && w_done)) begin
            n_row = '0;
            n_col = '0;
            n_dir = DIR_RIGHT;
            n_rb  = w_cols_s;
            n_bb  = w_rows_s;
            n_tb  = '0;
            n_lb  = -ONE;
        end

        if (i_cmd.clear) begin
            n_lidx = '0;
        end else if (i_cmd.load) begin
            n_lidx = (w_lidx_inc >= w_cells) ? '0 : w_lidx_inc;
        end
    end

endmodule

`default_nettype wire
